/* sv/btpc_pkg.sv */
// Package: shared types, constants and helpers for the baro compensation block.
`default_nettype none
package btpc_pkg;
    localparam int unsigned RAW_W  = 20;
    localparam int unsigned CAL_W  = 16;
    localparam int unsigned WIDE_W = 64;
    localparam int unsigned WORD_W = 32;
    localparam int unsigned IDX_W  = 3;
    localparam int unsigned QUEUE_DEPTH = 4;

    localparam logic [IDX_W-1:0] REG_T1 = 3'd0;
    localparam logic [IDX_W-1:0] REG_T2 = 3'd1;
    localparam logic [IDX_W-1:0] REG_T3 = 3'd2;
    localparam logic [IDX_W-1:0] REG_P1 = 3'd3;
    localparam logic [IDX_W-1:0] REG_P25 = 3'd4;
    localparam logic [IDX_W-1:0] REG_P69 = 3'd5;

    localparam logic [31:0] C_64000   = 32'd64000;
    localparam logic [31:0] C_32768   = 32'd32768;
    localparam logic [31:0] C_1048576 = 32'd1048576;
    localparam logic [31:0] C_3125    = 32'd3125;
    localparam logic [31:0] C_128     = 32'd128;
    localparam logic [31:0] C_MSB     = 32'h8000_0000;

    typedef logic [31:0] word_t;

    typedef struct packed {
        word_t t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
    } cal_t;

    // front-end classified item handed to the back end
    typedef struct packed {
        word_t temp;
        word_t fine;
        word_t num;
        word_t den;
        logic  dz;
    } front_t;

    function automatic word_t sx16(input logic [15:0] v);
        sx16 = {{16{v[15]}}, v};
    endfunction

    function automatic word_t mul(input word_t a, input word_t b);
        logic [63:0] f;
        f = a * b;
        mul = f[31:0];
    endfunction

    // arithmetic right shift of a 32-bit two's complement word
    function automatic word_t asr(input word_t x, input int unsigned n);
        asr = word_t'($signed(x) >>> n);
    endfunction
endpackage
`default_nettype wire

/* sv/btpc_front.sv */
// Front end: pipelined temperature and pressure-divisor math, one beat per cycle unless the output stalls.
`default_nettype none
module btpc_front (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire btpc_pkg::cal_t            cal,
    input  wire logic                      in_valid,
    output logic                           in_ready,
    input  wire logic [btpc_pkg::RAW_W-1:0] raw_temp,
    input  wire logic [btpc_pkg::RAW_W-1:0] raw_press,
    output logic                           out_valid,
    input  wire logic                      out_ready,
    output btpc_pkg::front_t               out_item
);
    import btpc_pkg::*;
    localparam int unsigned NST = 7;

    logic [NST-1:0] v_reg, v_next;
    logic adv;
    word_t rp_reg [NST-1];
    // stage 1
    word_t s1_x_reg, s1_d_reg;
    // stage 2
    word_t s2_a_reg, s2_dd_reg;
    // stage 3
    word_t s3_a_reg, s3_b_reg;
    // stage 4
    word_t s4_fine_reg, s4_t5_reg, s4_pa_reg, s4_sq_reg;
    // stage 5
    word_t s5_temp_reg, s5_fine_reg, s5_b1_reg, s5_b2_reg, s5_m3_reg, s5_m2_reg;
    // stage 6
    word_t s6_temp_reg, s6_fine_reg, s6_b_reg, s6_a_reg;
    // stage 7 (output)
    front_t o_reg;
    word_t  s6_a_sum, s6_bsum, a_sh;
    word_t  fine_c, pa_c;

    assign adv      = !v_reg[NST-1] || out_ready;
    assign in_ready = adv;
    assign out_valid = v_reg[NST-1];
    assign out_item  = o_reg;

    always_comb begin
        v_next = v_reg;
        if (adv) begin
            v_next = {v_reg[NST-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            v_reg <= v_next;
        end
    end

    always_comb begin
        fine_c   = s3_a_reg + asr(s3_b_reg, 14);
        pa_c     = asr(fine_c, 1) - C_64000;
        s6_a_sum = s5_m3_reg + s5_m2_reg;
        s6_bsum  = $signed(s5_b1_reg + s5_b2_reg) >>> 2;
        a_sh     = $signed(s6_a_reg) >>> 15;
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            rp_reg[0] <= word_t'(raw_press);
            for (int i = 1; i < NST - 1; i++) begin
                rp_reg[i] <= rp_reg[i-1];
            end
            s1_x_reg <= word_t'(raw_temp >> 3) - (cal.t1 << 1);
            s1_d_reg <= word_t'(raw_temp >> 4) - cal.t1;

            s2_a_reg  <= mul(s1_x_reg, cal.t2);
            s2_dd_reg <= mul(s1_d_reg, s1_d_reg);

            s3_a_reg <= $signed(s2_a_reg) >>> 11;
            s3_b_reg <= mul($signed(s2_dd_reg) >>> 12, cal.t3);

            s4_fine_reg <= fine_c;
            s4_t5_reg   <= mul(fine_c, 32'd5);
            s4_pa_reg   <= pa_c;
            s4_sq_reg   <= mul(asr(pa_c, 2), asr(pa_c, 2));

            s5_temp_reg <= $signed(s4_t5_reg + C_128) >>> 8;
            s5_fine_reg <= s4_fine_reg;
            s5_b1_reg   <= mul($signed(s4_sq_reg) >>> 11, cal.p6);
            s5_b2_reg   <= mul(s4_pa_reg, cal.p5) << 1;
            s5_m3_reg   <= $signed(mul(cal.p3, $signed(s4_sq_reg) >>> 13)) >>> 3;
            s5_m2_reg   <= $signed(mul(cal.p2, s4_pa_reg)) >>> 1;

            s6_temp_reg <= s5_temp_reg;
            s6_fine_reg <= s5_fine_reg;
            s6_b_reg    <= s6_bsum + (cal.p4 << 16);
            s6_a_reg    <= mul(C_32768 + asr(s6_a_sum, 18), cal.p1);

            o_reg.temp <= s6_temp_reg;
            o_reg.fine <= s6_fine_reg;
            o_reg.den  <= a_sh;
            o_reg.dz   <= (a_sh == '0);
            o_reg.num  <= mul((C_1048576 - rp_reg[NST-2]) - asr(s6_b_reg, 12), C_3125);
        end
    end
endmodule
`default_nettype wire

/* sv/btpc_fifo.sv */
// Short queue between front and back ends.
`default_nettype none
module btpc_fifo #(
    parameter int unsigned DEPTH = btpc_pkg::QUEUE_DEPTH
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire btpc_pkg::front_t in_item,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output btpc_pkg::front_t      out_item
);
    import btpc_pkg::*;
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    front_t mem_reg [DEPTH];
    logic [AW-1:0] wp_reg, wp_next, rp_reg, rp_next;
    logic [AW:0]   cnt_reg, cnt_next;
    logic push, pop;

    assign in_ready  = (cnt_reg != (AW+1)'(DEPTH));
    assign out_valid = (cnt_reg != '0);
    assign out_item  = mem_reg[rp_reg];
    assign push = in_valid && in_ready;
    assign pop  = out_valid && out_ready;

    always_comb begin
        wp_next  = wp_reg;
        rp_next  = rp_reg;
        cnt_next = cnt_reg;
        if (push) begin
            wp_next = (wp_reg == AW'(DEPTH-1)) ? '0 : wp_reg + 1'b1;
        end
        if (pop) begin
            rp_next = (rp_reg == AW'(DEPTH-1)) ? '0 : rp_reg + 1'b1;
        end
        if (push && !pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
        if (push) begin
            mem_reg[wp_reg] <= in_item;
        end
    end
endmodule
`default_nettype wire

/* sv/btpc_back.sv */
// Back end: pipelined restoring divider and final pressure correction.
`default_nettype none
module btpc_back (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire btpc_pkg::cal_t   cal,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire btpc_pkg::front_t in_item,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output logic [31:0]           temp_centideg,
    output logic [31:0]           fine_temp,
    output logic [31:0]           press_pa,
    output logic                  div_zero
);
    import btpc_pkg::*;
    localparam int unsigned DST = 8;          // divider stages, 4 quotient bits each
    localparam int unsigned BPS = WORD_W / DST;
    localparam int unsigned NST = DST + 4;

    typedef struct packed {
        word_t temp;
        word_t fine;
        logic  dz;
        logic  big;
        word_t den;
        word_t q;
        logic [32:0] rem;
        word_t dvd;
    } dv_t;

    logic [NST-1:0] v_reg, v_next;
    logic adv;
    dv_t d_reg [DST+1];
    dv_t d_cmb [DST];
    word_t e_temp_reg, e_fine_reg, e_p_reg, e_w1a_reg, e_w2_reg;
    logic  e_dz_reg;
    word_t f_temp_reg, f_fine_reg, f_p_reg, f_w1_reg, f_w2_reg;
    logic  f_dz_reg;
    word_t o_temp_reg, o_fine_reg, o_p_reg;
    logic  o_dz_reg;
    word_t qfin, p3, p2, s_w;

    assign adv       = !v_reg[NST-1] || out_ready;
    assign in_ready  = adv;
    assign out_valid = v_reg[NST-1];
    assign temp_centideg = o_temp_reg;
    assign fine_temp     = o_fine_reg;
    assign press_pa      = o_p_reg;
    assign div_zero      = o_dz_reg;

    always_comb begin
        v_next = v_reg;
        if (adv) begin
            v_next = {v_reg[NST-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            v_reg <= v_next;
        end
    end

    always_comb begin
        for (int s = 0; s < DST; s++) begin
            d_cmb[s] = d_reg[s];
            for (int k = 0; k < BPS; k++) begin
                d_cmb[s].rem = {d_cmb[s].rem[31:0], d_cmb[s].dvd[31]};
                d_cmb[s].dvd = d_cmb[s].dvd << 1;
                if (d_cmb[s].rem >= {1'b0, d_cmb[s].den}) begin
                    d_cmb[s].rem = d_cmb[s].rem - {1'b0, d_cmb[s].den};
                    d_cmb[s].q   = {d_cmb[s].q[30:0], 1'b1};
                end else begin
                    d_cmb[s].q   = {d_cmb[s].q[30:0], 1'b0};
                end
            end
        end
        qfin = d_reg[DST].big ? (d_reg[DST].q << 1) : d_reg[DST].q;
        p3   = qfin >> 3;
        p2   = qfin >> 2;
        s_w  = f_w1_reg + f_w2_reg + cal.p7;
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            d_reg[0].temp <= in_item.temp;
            d_reg[0].fine <= in_item.fine;
            d_reg[0].dz   <= in_item.dz;
            d_reg[0].big  <= in_item.num[31];
            d_reg[0].den  <= in_item.dz ? 32'd1 : in_item.den;
            d_reg[0].q    <= '0;
            d_reg[0].rem  <= '0;
            d_reg[0].dvd  <= in_item.num[31] ? in_item.num : (in_item.num << 1);
            for (int s = 0; s < DST; s++) begin
                d_reg[s+1] <= d_cmb[s];
            end

            e_temp_reg <= d_reg[DST].temp;
            e_fine_reg <= d_reg[DST].fine;
            e_dz_reg   <= d_reg[DST].dz;
            e_p_reg    <= qfin;
            e_w1a_reg  <= mul(p3, p3) >> 13;
            e_w2_reg   <= mul(p2, cal.p8);

            f_temp_reg <= e_temp_reg;
            f_fine_reg <= e_fine_reg;
            f_dz_reg   <= e_dz_reg;
            f_p_reg    <= e_p_reg;
            f_w1_reg   <= $signed(mul(cal.p9, e_w1a_reg)) >>> 12;
            f_w2_reg   <= $signed(e_w2_reg) >>> 13;

            o_temp_reg <= f_temp_reg;
            o_fine_reg <= f_fine_reg;
            o_dz_reg   <= f_dz_reg;
            o_p_reg    <= f_dz_reg ? '0 : f_p_reg + asr(s_w, 4);
        end
    end
endmodule
`default_nettype wire

/* sv/baro_temp_pressure_compensation.sv */
// Path from the accepting edge to m_valid: 7 front stages, the queue, then 12 back stages;
// output stalls hold beats in flight. Queue holds up to 4 beats.
// Throughput: one beat per cycle; front and back pipelines each stall on their own.
// The divide is an 8-stage restoring divider, 4 quotient bits per stage.
// Reset: synchronous active-low aresetn clears valid flags and calibration registers.
// Calibration registers reset to zero.
`default_nettype none
module baro_temp_pressure_compensation (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       cfg_we,
    input  wire logic [btpc_pkg::IDX_W-1:0] cfg_index,
    input  wire logic [btpc_pkg::WIDE_W-1:0] cfg_data,
    input  wire logic                       s_valid,
    output logic                            s_ready,
    input  wire logic [btpc_pkg::RAW_W-1:0] s_raw_temp,
    input  wire logic [btpc_pkg::RAW_W-1:0] s_raw_press,
    output logic                            m_valid,
    input  wire logic                       m_ready,
    output logic signed [31:0]              m_temp_centideg,
    output logic signed [31:0]              m_fine_temp,
    output logic [31:0]                     m_press_pa,
    output logic                            m_div_zero
);
    import btpc_pkg::*;

    logic [CAL_W-1:0] t1_reg, t2_reg, t3_reg, p1_reg;
    logic [WIDE_W-1:0] p25_reg, p69_reg;
    cal_t cal;
    logic fv, fr, qv, qr;
    front_t fi, qi;
    logic [31:0] tc, ft;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            t1_reg <= '0; t2_reg <= '0; t3_reg <= '0; p1_reg <= '0;
            p25_reg <= '0; p69_reg <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_T1:  t1_reg  <= cfg_data[CAL_W-1:0];
                REG_T2:  t2_reg  <= cfg_data[CAL_W-1:0];
                REG_T3:  t3_reg  <= cfg_data[CAL_W-1:0];
                REG_P1:  p1_reg  <= cfg_data[CAL_W-1:0];
                REG_P25: p25_reg <= cfg_data;
                REG_P69: p69_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        cal.t1 = {16'd0, t1_reg};
        cal.t2 = sx16(t2_reg);
        cal.t3 = sx16(t3_reg);
        cal.p1 = {16'd0, p1_reg};
        cal.p2 = sx16(p25_reg[15:0]);
        cal.p3 = sx16(p25_reg[31:16]);
        cal.p4 = sx16(p25_reg[47:32]);
        cal.p5 = sx16(p25_reg[63:48]);
        cal.p6 = sx16(p69_reg[15:0]);
        cal.p7 = sx16(p69_reg[31:16]);
        cal.p8 = sx16(p69_reg[47:32]);
        cal.p9 = sx16(p69_reg[63:48]);
    end

    btpc_front u_front (
        .aclk(aclk), .aresetn(aresetn), .cal(cal),
        .in_valid(s_valid), .in_ready(s_ready),
        .raw_temp(s_raw_temp), .raw_press(s_raw_press),
        .out_valid(fv), .out_ready(fr), .out_item(fi)
    );

    btpc_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(fv), .in_ready(fr), .in_item(fi),
        .out_valid(qv), .out_ready(qr), .out_item(qi)
    );

    btpc_back u_back (
        .aclk(aclk), .aresetn(aresetn), .cal(cal),
        .in_valid(qv), .in_ready(qr), .in_item(qi),
        .out_valid(m_valid), .out_ready(m_ready),
        .temp_centideg(tc), .fine_temp(ft),
        .press_pa(m_press_pa), .div_zero(m_div_zero)
    );

    assign m_temp_centideg = $signed(tc);
    assign m_fine_temp     = $signed(ft);
endmodule
`default_nettype wire

/* tb/baro_temp_pressure_compensation_tb.sv */
// Testbench for the barometric compensation block: scoreboard class, drivers, random beats.
`timescale 1ns / 100ps
`default_nettype none
module baro_temp_pressure_compensation_tb;
    import btpc_pkg::*;

    typedef struct {
        logic [31:0] temp;
        logic [31:0] fine;
        logic [31:0] press;
        logic        dz;
    } comp_res_t;

    class comp_scoreboard;
        logic [15:0] t1, t2, t3, p1;
        logic [63:0] p25, p69;
        comp_res_t   pending[$];
        int          errors;

        function void write_cal(logic [IDX_W-1:0] idx, logic [63:0] v);
            case (idx)
                REG_T1: t1 = v[15:0];
                REG_T2: t2 = v[15:0];
                REG_T3: t3 = v[15:0];
                REG_P1: p1 = v[15:0];
                REG_P25: p25 = v;
                REG_P69: p69 = v;
                default: ;
            endcase
        endfunction

        function logic [31:0] asr(logic [31:0] x, int n);
            return $unsigned($signed(x) >>> n);
        endfunction

        function logic [31:0] m32(logic [31:0] a, logic [31:0] b);
            logic [63:0] f;
            f = {32'd0, a} * {32'd0, b};
            return f[31:0];
        endfunction

        function logic [31:0] s16(logic [15:0] v);
            return {{16{v[15]}}, v};
        endfunction

        function void note_reading(logic [19:0] rt_in, logic [19:0] rp_in);
            comp_res_t r;
            logic [31:0] rt, rp, ut1, st2, st3, up1, a, b, d, fine, q, sq, p, w1, w2;
            logic [31:0] c2, c3, c4, c5, c6, c7, c8, c9;
            rt = {12'd0, rt_in};
            rp = {12'd0, rp_in};
            ut1 = {16'd0, t1};
            st2 = s16(t2);
            st3 = s16(t3);
            up1 = {16'd0, p1};
            c2 = s16(p25[15:0]);  c3 = s16(p25[31:16]);
            c4 = s16(p25[47:32]); c5 = s16(p25[63:48]);
            c6 = s16(p69[15:0]);  c7 = s16(p69[31:16]);
            c8 = s16(p69[47:32]); c9 = s16(p69[63:48]);
            a = asr(m32(asr(rt, 3) - (ut1 << 1), st2), 11);
            d = asr(rt, 4) - ut1;
            b = asr(m32(asr(m32(d, d), 12), st3), 14);
            fine = a + b;
            r.temp = asr(m32(fine, 32'd5) + C_128, 8);
            r.fine = fine;
            a = asr(fine, 1) - C_64000;
            q = asr(a, 2);
            sq = m32(q, q);
            b = m32(asr(sq, 11), c6);
            b = b + (m32(a, c5) << 1);
            b = asr(b, 2) + (c4 << 16);
            a = asr(asr(m32(c3, asr(sq, 13)), 3) + asr(m32(c2, a), 1), 18);
            a = asr(m32(C_32768 + a, up1), 15);
            r.dz = (a == 0);
            if (r.dz) begin
                p = 0;
            end else begin
                p = m32((C_1048576 - rp) - asr(b, 12), C_3125);
                if (p < C_MSB) p = (p << 1) / a;
                else p = (p / a) * 2;
                w1 = asr(m32(c9, m32(p >> 3, p >> 3) >> 13), 12);
                w2 = asr(m32(p >> 2, c8), 13);
                p = p + asr(w1 + w2 + c7, 4);
            end
            r.press = p;
            pending.push_back(r);
        endfunction

        function void check_result(logic [31:0] temp, logic [31:0] fine,
                                   logic [31:0] press, logic dz);
            comp_res_t e;
            if (pending.size() == 0) begin
                $display("%0t unexpected result temp=%h", $time, temp);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (temp !== e.temp) begin
                $display("%0t temp exp %h got %h", $time, e.temp, temp); errors++;
            end
            if (fine !== e.fine) begin
                $display("%0t fine exp %h got %h", $time, e.fine, fine); errors++;
            end
            if (press !== e.press) begin
                $display("%0t press exp %h got %h", $time, e.press, press); errors++;
            end
            if (dz !== e.dz) begin
                $display("%0t div_zero exp %b got %b", $time, e.dz, dz); errors++;
            end
        endfunction
    endclass

    logic aclk, aresetn, cfg_we, s_valid, s_ready, m_valid, m_ready, m_div_zero;
    logic [IDX_W-1:0] cfg_index;
    logic [WIDE_W-1:0] cfg_data;
    logic [RAW_W-1:0] s_raw_temp, s_raw_press;
    logic signed [31:0] m_temp_centideg, m_fine_temp;
    logic [31:0] m_press_pa;

    comp_scoreboard sb;
    bit hold_sink;
    bit rx_idle_on;

    baro_temp_pressure_compensation dut (.*);

    initial begin
        aclk = 0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #50_000_000;
        $display("TB_ERROR");
        $finish;
    end

    task automatic write_cal(logic [IDX_W-1:0] idx, logic [63:0] v);
        cfg_we <= 1; cfg_index <= idx; cfg_data <= v;
        sb.write_cal(idx, v);
        @(posedge aclk);
        cfg_we <= 0;
        @(posedge aclk);
    endtask

    task automatic send_reading(logic [19:0] rt, logic [19:0] rp, int gap);
        if (gap > 0) begin
            s_valid <= 0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1; s_raw_temp <= rt; s_raw_press <= rp;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_reading(rt, rp);
    endtask

    task automatic drain();
        s_valid <= 0;
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (30) @(posedge aclk);
    endtask

    function automatic int gap_draw();
        return ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
    endfunction

    // sink: random stall per beat, long hold-off on request
    initial begin
        int w;
        m_ready = 0;
        @(posedge aresetn);
        forever begin
            @(posedge aclk);
            if (m_valid && m_ready) begin
                sb.check_result(m_temp_centideg, m_fine_temp, m_press_pa, m_div_zero);
                w = rx_idle_on ? $urandom_range(0, 11) : 0;
                if (hold_sink || w > 0) begin
                    m_ready <= 0;
                    repeat (w) @(posedge aclk);
                end
            end else if (hold_sink) begin
                m_ready <= 0;
            end else begin
                m_ready <= 1;
            end
        end
    end

    // default working point close to a real sensor's calibration
    task automatic typical_cal();
        write_cal(REG_T1, 64'd27504);
        write_cal(REG_T2, 64'd26435);
        write_cal(REG_T3, 64'hFFFF_FFFF_FFFF_FC18);
        write_cal(REG_P1, 64'd36477);
        write_cal(REG_P25, {16'd8000 >> 0, 16'd2855, 16'd3024, 16'hD5D4} ^ 64'd0
                  | {16'h0000, 16'h0000, 16'h0000, 16'h0000});
        write_cal(REG_P69, {16'd6000, 16'hC6F0, 16'd15500, 16'hFFF9});
    endtask

    task automatic random_cal();
        write_cal(REG_T1, {$urandom, $urandom});
        write_cal(REG_T2, {$urandom, $urandom});
        write_cal(REG_T3, {$urandom, $urandom});
        write_cal(REG_P1, {$urandom, $urandom});
        write_cal(REG_P25, {$urandom, $urandom});
        write_cal(REG_P69, {$urandom, $urandom});
    endtask

    task automatic random_phase(int n);
        for (int i = 0; i < n; i++)
            send_reading(20'($urandom), 20'($urandom), gap_draw());
    endtask

    initial begin
        sb = new();
        aresetn = 0; cfg_we = 0; cfg_index = 0; cfg_data = 0;
        s_valid = 0; s_raw_temp = 0; s_raw_press = 0;
        hold_sink = 0; rx_idle_on = 1;
        sb.write_cal(REG_T1, 0); sb.write_cal(REG_T2, 0); sb.write_cal(REG_T3, 0);
        sb.write_cal(REG_P1, 0); sb.write_cal(REG_P25, 0); sb.write_cal(REG_P69, 0);
        repeat (5) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // reset calibration: divisor zero
        send_reading(20'h00000, 20'hFFFFF, 0);
        send_reading(20'hFFFFF, 20'h00000, 1);
        drain();
        write_cal(3'd6, 64'hFFFF);
        write_cal(3'd7, 64'hFFFF);
        send_reading(20'h55555, 20'hAAAAA, 0);
        drain();

        typical_cal();
        send_reading(20'd519888, 20'd415148, 0);
        send_reading(20'h00000, 20'h00000, 0);
        send_reading(20'hFFFFF, 20'hFFFFF, 0);
        send_reading(20'h80000, 20'h7FFFF, 2);
        send_reading(20'hAAAAA, 20'h55555, 0);
        drain();

        // extremes
        write_cal(REG_T1, 64'hFFFF); write_cal(REG_T2, 64'h7FFF);
        write_cal(REG_T3, 64'h8000); write_cal(REG_P1, 64'hFFFF);
        write_cal(REG_P25, 64'h8000_7FFF_8000_7FFF);
        write_cal(REG_P69, 64'h7FFF_8000_7FFF_8000);
        send_reading(20'h00000, 20'hFFFFF, 0);
        send_reading(20'hFFFFF, 20'h00000, 0);
        send_reading(20'h12345, 20'h6789A, 0);
        drain();
        write_cal(REG_T2, 64'h8000); write_cal(REG_T3, 64'h7FFF);
        write_cal(REG_P1, 64'd1);
        write_cal(REG_P25, 64'h7FFF_8000_7FFF_8000);
        write_cal(REG_P69, 64'h8000_7FFF_8000_7FFF);
        send_reading(20'hFFFFF, 20'hFFFFF, 0);
        send_reading(20'h00000, 20'h00000, 0);
        send_reading(20'h7FFFF, 20'h80000, 0);
        drain();

        // long receiver hold-off: block fills and stalls its input
        typical_cal();
        hold_sink <= 1;
        fork
            begin repeat (200) @(posedge aclk); hold_sink <= 0; end
            random_phase(40);
        join
        drain();

        for (int ph = 0; ph < 10; ph++) begin
            rx_idle_on = (ph % 3 != 2);
            if (ph % 2 == 0) typical_cal();
            else random_cal();
            if (ph == 4) write_cal(REG_P1, 64'd0);
            random_phase(100);
            drain();
        end

        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule
`default_nettype wire

/* filelist.f */
sv/btpc_pkg.sv
sv/btpc_front.sv
sv/btpc_fifo.sv
sv/btpc_back.sv
sv/baro_temp_pressure_compensation.sv
tb/baro_temp_pressure_compensation_tb.sv
